// ===== hdl/mfir_pkg.sv =====
// ----------------------------------------------------------------------------
// mfir_pkg
// Shared sizes, register indexes, types and arithmetic helpers of the
// multichannel FIR filter.
// ----------------------------------------------------------------------------
package mfir_pkg;

    // Block sizing.
    localparam int CHANNELS = 8;
    localparam int MAX_TAPS = 16;

    // Field widths.
    localparam int CH_W      = 3;
    localparam int SMP_W     = 12;
    localparam int FILT_W    = 18;
    localparam int COEF_W    = 16;
    localparam int TCNT_W    = 5;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;

    // Coefficient packing: four coefficients per 64-bit register.
    localparam int COEF_REGS     = 4;
    localparam int COEFS_PER_REG = CFG_W / COEF_W;

    // Fixed point: coefficients are Q2.14.
    localparam int Q_SHIFT    = 14;
    localparam int ROUND_HALF = 2 ** (Q_SHIFT - 1);

    // Derived sizes.
    localparam int TAP_W      = $clog2(MAX_TAPS);
    localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int HIST_DEPTH = CHANNELS * MAX_TAPS;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int PROD_W     = COEF_W + SMP_W;
    localparam int ACC_W      = PROD_W + TAP_W;
    localparam int Q_W        = ACC_W - Q_SHIFT + 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_COEF_0_3    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_COEF_4_7    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_COEF_8_11   = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_COEF_12_15  = CFG_IDX_W'(4);

    // Reset values: sixteen taps, tap 0 at unity gain.
    localparam logic [TCNT_W-1:0] TAP_COUNT_RST = TCNT_W'(16);
    localparam logic [CFG_W-1:0]  COEF_0_3_RST  = CFG_W'(16384);

    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic signed [ACC_W-1:0]  t_acc;
    typedef logic signed [Q_W-1:0]    t_q;
    typedef logic signed [FILT_W-1:0] t_filt;

    localparam t_q    Q_HI    = t_q'(2 ** (FILT_W - 1) - 1);
    localparam t_q    Q_LO    = t_q'(-(2 ** (FILT_W - 1)));
    localparam t_filt FILT_HI = t_filt'(2 ** (FILT_W - 1) - 1);
    localparam t_filt FILT_LO = t_filt'(-(2 ** (FILT_W - 1)));

    // Link between neighboring cells: a marker that travels with the sum.
    typedef struct packed {
        logic token;
        t_acc sum;
    } t_link;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_WAIT,
        ST_OUT
    } t_state;

    // Tap count clamped to one up to MAX_TAPS.
    function automatic logic [TCNT_W-1:0] eff_taps(input logic [TCNT_W-1:0] t);
        logic [TCNT_W-1:0] res;
        if (t == '0) begin
            res = TCNT_W'(1);
        end else if (t > TCNT_W'(MAX_TAPS)) begin
            res = TCNT_W'(MAX_TAPS);
        end else begin
            res = t;
        end
        return res;
    endfunction

    // Round half up, floor shift by the Q width, saturate to the output width.
    function automatic t_filt round_sat(input t_acc acc);
        logic signed [ACC_W:0] v;
        t_q                    q;
        t_filt                 res;
        v = (ACC_W + 1)'(acc) + (ACC_W + 1)'(ROUND_HALF);
        q = v[ACC_W:Q_SHIFT];
        if (q > Q_HI) begin
            res = FILT_HI;
        end else if (q < Q_LO) begin
            res = FILT_LO;
        end else begin
            res = q[FILT_W-1:0];
        end
        return res;
    endfunction

    // History address of one position in one channel's row.
    function automatic logic [HIST_AW-1:0] hist_addr(input logic [CH_IDX_W-1:0] ch,
                                                     input logic [TAP_W-1:0] pos);
        return HIST_AW'(int'(ch) * MAX_TAPS + int'(pos));
    endfunction

endpackage

// ===== hdl/mfir_if.sv =====
// ----------------------------------------------------------------------------
// mfir_if
// Valid/ready channels of the FIR filter: sample beats in, result beats out.
// ----------------------------------------------------------------------------

// Input channel: one tagged ADC sample per beat.
interface mfir_in_if import mfir_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CH_W-1:0]  channel;
    logic [SMP_W-1:0] sample;

    modport source (output valid, output channel, output sample, input ready);
    modport sink   (input valid, input channel, input sample, output ready);
endinterface

// Output channel: one filtered result per beat.
interface mfir_out_if import mfir_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CH_W-1:0]          out_channel;
    logic signed [FILT_W-1:0] filtered;
    logic [SMP_W-1:0]         raw_sample;

    modport source (output valid, output out_channel, output filtered,
                    output raw_sample, input ready);
    modport sink   (input valid, input out_channel, input filtered,
                    input raw_sample, output ready);
endinterface

// ===== hdl/mfir_hist.sv =====
// ----------------------------------------------------------------------------
// mfir_hist
// Sample history memory, one row of MAX_TAPS entries per channel, with a
// valid bit per entry so that unwritten entries read as zero.
// ----------------------------------------------------------------------------
module mfir_hist import mfir_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_we,
    input  logic [HIST_AW-1:0] i_waddr,
    input  logic [SMP_W-1:0]   i_wdata,
    input  logic [HIST_AW-1:0] i_raddr,
    output logic [SMP_W-1:0]   o_rdata
);

    logic [SMP_W-1:0]      r_mem [HIST_DEPTH];
    logic [SMP_W-1:0]      r_rdata;
    logic [HIST_DEPTH-1:0] r_vld;
    logic                  r_rvld;

    // Storage array with one write and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    // Entry valid bits, cleared at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            r_rvld <= r_vld[i_raddr];
        end
    end

    assign o_rdata = r_rvld ? r_rdata : '0;

endmodule

// ===== hdl/mfir_cell.sv =====
// ----------------------------------------------------------------------------
// mfir_cell
// One tap of the multiply-accumulate chain. The running sum arrives from the
// left neighbor together with a token; the cell adds its coefficient times
// the sample on the shared bus and hands the sum to the right neighbor.
// ----------------------------------------------------------------------------
module mfir_cell import mfir_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_coef            i_coef,
    input  logic             i_tap_en,
    input  logic [SMP_W-1:0] i_sample,
    input  t_link            i_link,
    output t_link            o_link
);

    logic signed [PROD_W-1:0] w_prod;
    logic                     r_token;
    t_acc                     r_sum;

    // Coefficient times the unsigned sample.
    assign w_prod = PROD_W'(i_coef) * PROD_W'($signed({1'b0, i_sample}));

    // Token travels one cell per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_token <= 1'b0;
        end else begin
            r_token <= i_link.token;
        end
    end

    // Accumulate when this tap is in use, otherwise pass the sum along.
    always_ff @(posedge i_clk) begin
        r_sum <= i_link.sum + (i_tap_en ? ACC_W'(w_prod) : '0);
    end

    assign o_link.token = r_token;
    assign o_link.sum   = r_sum;

endmodule

// ===== hdl/multichannel_fir_filter.sv =====
// ----------------------------------------------------------------------------
// multichannel_fir_filter
// Time-multiplexed FIR filter over eight ADC channels with per-channel
// circular sample history and a chain of multiply-accumulate cells.
// ----------------------------------------------------------------------------
// Usage:
//   A sample beat on i_smp carries a channel tag and a 12-bit ADC value. The
//   sample is stored in that channel's history, and one result beat on o_res
//   returns the channel, the raw sample and the filtered value: the Q2.14
//   weighted sum of the newest tap_count samples, rounded, shifted by 14 and
//   saturated to 18 bits.
//   Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_data while no
//   sample is in flight (a user rule; the block does not enforce it): index 0
//   is the tap count, indexes 1 to 4 hold four coefficients each, tap 0 lowest.
//   Sequence: after a sample beat is taken, the history is read newest first
//   over all MAX_TAPS positions, one tap per cycle to the cell chain; the
//   registered memory read feeds the cells, a token carries the sum down the
//   chain, the accumulator captures it and the result enters the output
//   register. i_smp.ready returns together with that load, so the block does
//   not take a new sample while one is still in flight.
//   Reset clears all history to zero, all write positions to zero, the tap
//   count to 16 and the coefficients to a unity tap 0.
//   A stalled receiver holds the result in the output register; a new sample
//   is still accepted, and its result waits until the register is free.
// ----------------------------------------------------------------------------
module multichannel_fir_filter import mfir_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    mfir_in_if.sink              i_smp,
    mfir_out_if.source           o_res
);

    // Configuration registers.
    logic [TCNT_W-1:0] r_tap_count;
    logic [CFG_W-1:0]  r_coef [COEF_REGS];
    logic [TCNT_W-1:0] w_taps;

    // Control.
    t_state            r_state;
    t_state            n_state;
    logic [TAP_W-1:0]  r_cnt;
    logic              r_first;
    logic              w_acc_in;
    logic              w_done;
    logic              w_out_free;

    // Per-channel write positions.
    logic [TAP_W-1:0]    r_wpos [CHANNELS];
    logic [CH_IDX_W-1:0] w_in_ch;
    logic                w_in_ok;
    logic [TAP_W-1:0]    w_pos_rd;
    logic [TAP_W-1:0]    w_pos;
    logic [TCNT_W-1:0]   w_pos_inc;
    logic [TAP_W-1:0]    w_pos_next;
    logic                w_hist_we;

    // Item in flight.
    logic [CH_W-1:0]  r_ch;
    logic [SMP_W-1:0] r_smp;
    logic             r_ch_ok;
    logic [TAP_W-1:0] r_rd;
    logic [SMP_W-1:0] w_rsample;
    t_acc             r_acc;

    // Cell chain.
    t_link             w_chain [MAX_TAPS + 1];
    logic [MAX_TAPS-1:0] w_tokens;

    // Output register.
    logic             r_ovalid;
    logic [CH_W-1:0]  r_och;
    t_filt            r_ofilt;
    logic [SMP_W-1:0] r_oraw;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= TAP_COUNT_RST;
            r_coef[0]   <= COEF_0_3_RST;
            for (int k = 1; k < COEF_REGS; k++) begin
                r_coef[k] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_TAP_COUNT:  r_tap_count <= i_cfg_data[TCNT_W-1:0];
                REG_COEF_0_3:   r_coef[0]   <= i_cfg_data;
                REG_COEF_4_7:   r_coef[1]   <= i_cfg_data;
                REG_COEF_8_11:  r_coef[2]   <= i_cfg_data;
                REG_COEF_12_15: r_coef[3]   <= i_cfg_data;
                default:        ;
            endcase
        end
    end

    assign w_taps = eff_taps(r_tap_count);

    // Input handshake and write position for the incoming sample.
    assign i_smp.ready = (r_state == ST_IDLE);
    assign w_acc_in    = i_smp.valid && i_smp.ready;
    assign w_in_ch     = i_smp.channel[CH_IDX_W-1:0];
    assign w_in_ok     = {1'b0, i_smp.channel} < (CH_W + 1)'(CHANNELS);
    assign w_pos_rd    = r_wpos[w_in_ch];
    assign w_pos       = (TCNT_W'(w_pos_rd) >= w_taps) ? '0 : w_pos_rd;
    assign w_pos_inc   = TCNT_W'(w_pos) + TCNT_W'(1);
    assign w_pos_next  = (w_pos_inc >= w_taps) ? '0 : w_pos_inc[TAP_W-1:0];
    assign w_hist_we   = w_acc_in && w_in_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CHANNELS; k++) begin
                r_wpos[k] <= '0;
            end
        end else if (w_hist_we) begin
            r_wpos[w_in_ch] <= w_pos_next;
        end
    end

    // Sample history.
    mfir_hist u_hist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_hist_we),
        .i_waddr (hist_addr(w_in_ch, w_pos)),
        .i_wdata (i_smp.sample),
        .i_raddr (hist_addr(r_ch[CH_IDX_W-1:0], r_rd)),
        .o_rdata (w_rsample)
    );

    // Item registers and the newest-first read pointer.
    always_ff @(posedge i_clk) begin
        if (w_acc_in) begin
            r_ch    <= i_smp.channel;
            r_smp   <= i_smp.sample;
            r_ch_ok <= w_in_ok;
            r_rd    <= w_pos;
        end else if (r_state == ST_READ) begin
            r_rd <= (r_rd == '0) ? (w_taps[TAP_W-1:0] - TAP_W'(1)) : (r_rd - TAP_W'(1));
        end
        if (w_done) begin
            r_acc <= w_chain[MAX_TAPS].sum;
        end
    end

    // Tap counter and the token that starts the chain with tap 0's data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_first <= 1'b0;
        end else begin
            if (w_acc_in) begin
                r_cnt <= '0;
            end else if (r_state == ST_READ) begin
                r_cnt <= r_cnt + TAP_W'(1);
            end
            r_first <= (r_state == ST_READ) && (r_cnt == '0);
        end
    end

    // Row of multiply-accumulate cells, one per tap.
    assign w_chain[0].token = r_first;
    assign w_chain[0].sum   = '0;

    for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
        mfir_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_coef   (t_coef'(r_coef[k / COEFS_PER_REG][(k % COEFS_PER_REG) * COEF_W +: COEF_W])),
            .i_tap_en (TCNT_W'(k) < w_taps),
            .i_sample (w_rsample),
            .i_link   (w_chain[k]),
            .o_link   (w_chain[k + 1])
        );
        assign w_tokens[k] = w_chain[k + 1].token;
    end

    assign w_done = w_chain[MAX_TAPS].token;

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_acc_in) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                if (r_cnt == TAP_W'(MAX_TAPS - 1)) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (w_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Output register.
    assign w_out_free = !r_ovalid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if ((r_state == ST_OUT) && w_out_free) begin
            r_ovalid <= 1'b1;
        end else if (o_res.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_OUT) && w_out_free) begin
            r_och   <= r_ch;
            r_oraw  <= r_smp;
            r_ofilt <= r_ch_ok ? round_sat(r_acc) : '0;
        end
    end

    assign o_res.valid       = r_ovalid;
    assign o_res.out_channel = r_och;
    assign o_res.filtered    = r_ofilt;
    assign o_res.raw_sample  = r_oraw;

    // Only one item travels through the cell chain at a time.
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tokens))
        else $error("more than one token in the cell chain");

    // The finished sum emerges only while the sequencer waits for it.
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (r_state == ST_WAIT))
        else $error("chain result outside the wait state");

    // An idle block has nothing left in the chain.
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> ((w_tokens == '0) && !r_first))
        else $error("idle with a token still in the chain");

    // An accepted beat starts the tap sweep at tap 0.
    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc_in |=> ((r_state == ST_READ) && (r_cnt == '0)))
        else $error("tap sweep did not start after a sample beat");

    // A result appears only out of the output state.
    a_load_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> ($past(r_state) == ST_OUT))
        else $error("output loaded outside the output state");

endmodule
